// ===== hw/rtl/seq_pkg.sv =====
// ----------------------------------------------------------------------------
// seq_pkg: shared types and codes for the sorted event queue
// The entry layout, operation and status codes, and the per-cycle cell command.
// ----------------------------------------------------------------------------
package seq_pkg;

  localparam int unsigned KeyW   = 32;
  localparam int unsigned KindW  = 2;
  localparam int unsigned Tag1W  = 16;
  localparam int unsigned Tag2W  = 8;
  localparam int unsigned ClassW = 2;
  localparam int unsigned StatW  = 2;
  localparam int unsigned OccW   = 5;

  // operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_POP    = 1'b1;

  // status codes
  localparam logic [StatW-1:0] ST_OK    = 2'd0;
  localparam logic [StatW-1:0] ST_EMPTY = 2'd1;
  localparam logic [StatW-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [KeyW-1:0]          key;
    logic [KindW-1:0]         kind;
    logic signed [Tag1W-1:0]  tag1;
    logic signed [Tag2W-1:0]  tag2;
    logic [ClassW-1:0]        cls;
  } entry_t;

  // command broadcast to every cell in a cycle
  typedef struct packed {
    logic   insert;   // place new entry, shift the tail right
    logic   pop;      // shift everything one cell toward the head
    entry_t fresh;    // entry being inserted
  } cell_cmd_t;

endpackage

// ===== hw/rtl/seq_cell.sv =====
// ----------------------------------------------------------------------------
// seq_cell: one slot of the sorted queue
// Holds one entry and its valid bit; takes from the left on insert shift,
// from the right on pop, or the fresh entry where the insert lands.
// ----------------------------------------------------------------------------
module seq_cell
  import seq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cell_cmd_t cmd,
  input  logic      left_valid,
  input  entry_t    left_entry,
  input  logic      left_gt,
  input  logic      right_valid,
  input  entry_t    right_entry,
  output logic      valid,
  output entry_t    entry,
  output logic      gt
);

  // empty slots count as "greater", so the insert point is the first such slot
  assign gt = !valid || (entry.key > cmd.fresh.key);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.pop) begin
      valid <= right_valid;
    end else if (cmd.insert && gt) begin
      valid <= left_gt ? left_valid : 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pop) begin
      entry <= right_entry;
    end else if (cmd.insert && gt) begin
      entry <= left_gt ? left_entry : cmd.fresh;
    end
  end

endmodule

// ===== hw/rtl/sorted_event_queue_unit.sv =====
// ----------------------------------------------------------------------------
// sorted_event_queue_unit: stable sorted priority queue of timed events
// Each accepted word's result is registered and shown in the cycle after; throughput
// 1 word/cycle unless the output stalls, the cell row shifting once per word. Reset
// (sync, active high) empties the queue and the output register, not entry payloads.
// ----------------------------------------------------------------------------
module sorted_event_queue_unit
  import seq_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  // input channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     operation,
  input  logic [KeyW-1:0]          event_time,
  input  logic [KindW-1:0]         event_kind,
  input  logic signed [Tag1W-1:0]  first_tag,
  input  logic signed [Tag2W-1:0]  second_tag,
  input  logic [ClassW-1:0]        class_code,
  // output channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [StatW-1:0]         status,
  output logic [KeyW-1:0]          out_time,
  output logic [KindW-1:0]         out_kind,
  output logic signed [Tag1W-1:0]  out_first_tag,
  output logic signed [Tag2W-1:0]  out_second_tag,
  output logic [ClassW-1:0]        out_class,
  output logic [OccW-1:0]          occupancy
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  // --------------------------------------------------------------------------
  // Handshake: the output register is the only buffer. A new word enters
  // whenever the register is empty or being drained in the same cycle.
  // --------------------------------------------------------------------------
  logic accept;
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  // --------------------------------------------------------------------------
  // Fill count and operation decode
  // --------------------------------------------------------------------------
  logic [CntW-1:0] count;
  logic [CntW-1:0] count_next;
  logic            is_empty;
  logic            is_full;
  logic            do_pop;
  logic            do_insert;

  assign is_empty  = (count == '0);
  assign is_full   = (count == CntW'(DEPTH));
  assign do_pop    = accept && (operation == OP_POP) && !is_empty;
  assign do_insert = accept && (operation == OP_INSERT) && !is_full;

  always_comb begin
    count_next = count;
    if (do_pop) begin
      count_next = count - 1'b1;
    end else if (do_insert) begin
      count_next = count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // --------------------------------------------------------------------------
  // Cell row: cell 0 is the head (smallest key). Every cell compares its key
  // against the fresh one in parallel; the insert lands in the first cell that
  // is empty or strictly greater, so equal keys keep arrival order.
  // --------------------------------------------------------------------------
  cell_cmd_t cmd;
  assign cmd.insert       = do_insert;
  assign cmd.pop          = do_pop;
  assign cmd.fresh.key    = event_time;
  assign cmd.fresh.kind   = event_kind;
  assign cmd.fresh.tag1   = first_tag;
  assign cmd.fresh.tag2   = second_tag;
  assign cmd.fresh.cls    = class_code;

  logic   cell_valid [DEPTH];
  entry_t cell_entry [DEPTH];
  logic   cell_gt    [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic   lv;
    entry_t le;
    logic   lg;
    logic   rv;
    entry_t re;

    if (i == 0) begin : g_head
      assign lv = 1'b0;
      assign le = '0;
      assign lg = 1'b0;
    end else begin : g_mid
      assign lv = cell_valid[i-1];
      assign le = cell_entry[i-1];
      assign lg = cell_gt[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign rv = 1'b0;
      assign re = '0;
    end else begin : g_body
      assign rv = cell_valid[i+1];
      assign re = cell_entry[i+1];
    end

    seq_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .cmd         (cmd),
      .left_valid  (lv),
      .left_entry  (le),
      .left_gt     (lg),
      .right_valid (rv),
      .right_entry (re),
      .valid       (cell_valid[i]),
      .entry       (cell_entry[i]),
      .gt          (cell_gt[i])
    );
  end

  // --------------------------------------------------------------------------
  // Result register: a pop on a non-empty queue reports the head cell, everything else zeros.
  // Occupancy is the low bits of the count after the operation.
  // --------------------------------------------------------------------------
  logic [CntW+OccW-1:0] occ_wide;
  assign occ_wide = {{OccW{1'b0}}, count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_time       <= '0;
      out_kind       <= '0;
      out_first_tag  <= '0;
      out_second_tag <= '0;
      out_class      <= '0;
      occupancy      <= occ_wide[OccW-1:0];
      if (operation == OP_POP) begin
        if (is_empty) begin
          status <= ST_EMPTY;
        end else begin
          status         <= ST_OK;
          out_time       <= cell_entry[0].key;
          out_kind       <= cell_entry[0].kind;
          out_first_tag  <= cell_entry[0].tag1;
          out_second_tag <= cell_entry[0].tag2;
          out_class      <= cell_entry[0].cls;
        end
      end else begin
        status <= is_full ? ST_FULL : ST_OK;
      end
    end
  end

endmodule

// ===== bench/event_order_checker.sv =====
// ----------------------------------------------------------------------------
// event_order_checker: tracks the sorted event queue and scores its results
// Keeps its own ordered copy of the queue, works out the result due for every
// accepted input word and compares each accepted result word against it.
// ----------------------------------------------------------------------------
module event_order_checker
  import seq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic                     operation,
  input  logic [KeyW-1:0]          event_time,
  input  logic [KindW-1:0]         event_kind,
  input  logic signed [Tag1W-1:0]  first_tag,
  input  logic signed [Tag2W-1:0]  second_tag,
  input  logic [ClassW-1:0]        class_code,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic [StatW-1:0]         status,
  input  logic [KeyW-1:0]          out_time,
  input  logic [KindW-1:0]         out_kind,
  input  logic signed [Tag1W-1:0]  out_first_tag,
  input  logic signed [Tag2W-1:0]  out_second_tag,
  input  logic [ClassW-1:0]        out_class,
  input  logic [OccW-1:0]          occupancy,
  output int                       mismatches,
  output int                       pending
);

  typedef struct packed {
    logic [StatW-1:0] status;
    entry_t           item;
    logic [OccW-1:0]  occ;
  } outcome_t;

  entry_t   queued_events [DEPTH];
  int       held;
  outcome_t due_outcomes [$];

  initial begin
    held = 0;
    mismatches = 0;
    pending = 0;
  end

  // Applies one word to the shadow queue and returns the result it must give.
  function automatic outcome_t advance_queue(input logic op, input entry_t fresh);
    outcome_t r;
    int       pos;
    r = '0;
    if (op == OP_POP) begin
      if (held == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.item = queued_events[0];
        for (int i = 1; i < held; i++) queued_events[i-1] = queued_events[i];
        held--;
        r.status = ST_OK;
      end
    end else if (held >= DEPTH) begin
      r.status = ST_FULL;
    end else begin
      // stable: land after every held key that is <= the new one
      pos = 0;
      while (pos < held && queued_events[pos].key <= fresh.key) pos++;
      for (int i = held; i > pos; i--) queued_events[i] = queued_events[i-1];
      queued_events[pos] = fresh;
      held++;
      r.status = ST_OK;
    end
    r.occ = held[OccW-1:0];
    return r;
  endfunction

  always @(posedge clk) begin : watch
    outcome_t want;
    entry_t   fresh;
    if (rst) begin
      held = 0;
      due_outcomes.delete();
    end else begin
      // result side first: a word accepted now cannot belong to this edge's input
      if (out_valid && !out_stall) begin
        if (due_outcomes.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: result word with nothing outstanding (status %0d)",
                     $realtime, status);
          mismatches++;
        end else begin
          want = due_outcomes.pop_front();
          if (status !== want.status || out_time !== want.item.key ||
              out_kind !== want.item.kind || out_first_tag !== want.item.tag1 ||
              out_second_tag !== want.item.tag2 || out_class !== want.item.cls ||
              occupancy !== want.occ) begin
            if (mismatches < 10)
              $display({"%0t: mismatch exp/got status %0d/%0d time %h/%h kind %0d/%0d",
                        " tag1 %0d/%0d tag2 %0d/%0d class %0d/%0d occ %0d/%0d"},
                       $realtime, want.status, status, want.item.key, out_time,
                       want.item.kind, out_kind, want.item.tag1, out_first_tag,
                       want.item.tag2, out_second_tag, want.item.cls, out_class,
                       want.occ, occupancy);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        fresh.key  = event_time;
        fresh.kind = event_kind;
        fresh.tag1 = first_tag;
        fresh.tag2 = second_tag;
        fresh.cls  = class_code;
        due_outcomes.push_back(advance_queue(operation, fresh));
      end
    end
    pending = due_outcomes.size();
  end

endmodule

// ===== bench/sorted_event_queue_unit_tb.sv =====
// ----------------------------------------------------------------------------
// sorted_event_queue_unit_tb: stimulus and verdict for the sorted event queue
// Directed corner words (empty pop, extreme fields, equal keys, full queue)
// then phases of random inserts and pops with shifting bias, random idling on
// both channels. Scoring is done by event_order_checker.
// ----------------------------------------------------------------------------
module sorted_event_queue_unit_tb;
  import seq_pkg::*;

  localparam int DEPTH       = 16;
  localparam int CYCLE_LIMIT = 100000;  // well above the slowest legal run
  localparam int PHASES      = 12;
  localparam int PHASE_WORDS = 85;

  logic                     clk;
  logic                     rst;
  logic                     in_valid;
  logic                     in_stall;
  logic                     operation;
  logic [KeyW-1:0]          event_time;
  logic [KindW-1:0]         event_kind;
  logic signed [Tag1W-1:0]  first_tag;
  logic signed [Tag2W-1:0]  second_tag;
  logic [ClassW-1:0]        class_code;
  logic                     out_valid;
  logic                     out_stall;
  logic [StatW-1:0]         status;
  logic [KeyW-1:0]          out_time;
  logic [KindW-1:0]         out_kind;
  logic signed [Tag1W-1:0]  out_first_tag;
  logic signed [Tag2W-1:0]  out_second_tag;
  logic [ClassW-1:0]        out_class;
  logic [OccW-1:0]          occupancy;

  int   mismatches;
  int   pending;
  int   cycles;
  int   hold_left;   // result-side stall cycles still to serve
  logic quiet;       // no idling on either side while set

  sorted_event_queue_unit #(.DEPTH(DEPTH)) dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .operation      (operation),
    .event_time     (event_time),
    .event_kind     (event_kind),
    .first_tag      (first_tag),
    .second_tag     (second_tag),
    .class_code     (class_code),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .out_time       (out_time),
    .out_kind       (out_kind),
    .out_first_tag  (out_first_tag),
    .out_second_tag (out_second_tag),
    .out_class      (out_class),
    .occupancy      (occupancy)
  );

  event_order_checker #(.DEPTH(DEPTH)) scoreboard (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .operation      (operation),
    .event_time     (event_time),
    .event_kind     (event_kind),
    .first_tag      (first_tag),
    .second_tag     (second_tag),
    .class_code     (class_code),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .out_time       (out_time),
    .out_kind       (out_kind),
    .out_first_tag  (out_first_tag),
    .out_second_tag (out_second_tag),
    .out_class      (out_class),
    .occupancy      (occupancy),
    .mismatches     (mismatches),
    .pending        (pending)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // watchdog
  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Result side: after each accepted result word draw a random stall, none while quiet.
  // Stall is driven at the falling edge, the draw is made at the rising edge.
  always @(posedge clk) begin
    if (out_valid && !out_stall) hold_left = quiet ? 0 : $urandom_range(0, 3);
  end

  always @(negedge clk) begin
    out_stall = (hold_left != 0);
    if (hold_left != 0) hold_left = hold_left - 1;
  end

  // Offers one word; called at a falling edge, returns at the falling edge
  // after acceptance. Valid is only touched once per time step.
  task automatic offer_word(input logic op, input logic [KeyW-1:0] key,
                            input logic [KindW-1:0] kind,
                            input logic signed [Tag1W-1:0] t1,
                            input logic signed [Tag2W-1:0] t2,
                            input logic [ClassW-1:0] cls);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   = 1'b1;
    operation  = op;
    event_time = key;
    event_kind = kind;
    first_tag  = t1;
    second_tag = t2;
    class_code = cls;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Random word. Keys mix a tiny range (lots of ties), full range, the extremes and
  // coarse steps of 256; tags are mostly random bit patterns, sometimes "none".
  task automatic random_word(input int insert_pct);
    logic [KeyW-1:0]         key;
    logic signed [Tag1W-1:0] t1;
    logic signed [Tag2W-1:0] t2;
    logic                    op;
    case ($urandom_range(0, 3))
      0:       key = $urandom_range(0, 7);
      1:       key = $urandom;
      2:       key = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      default: key = $urandom_range(100, 140) << 8;
    endcase
    t1 = ($urandom_range(0, 3) == 0) ? -16'sd1 : Tag1W'($urandom);
    t2 = ($urandom_range(0, 3) == 0) ? -8'sd1 : Tag2W'($urandom);
    op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_POP;
    offer_word(op, key, KindW'($urandom), t1, t2, ClassW'($urandom));
  endtask

  initial begin : stimulus
    int pct;
    rst        = 1'b1;
    in_valid   = 1'b0;
    out_stall  = 1'b0;
    hold_left  = 0;
    quiet      = 1'b0;
    operation  = OP_INSERT;
    event_time = '0;
    event_kind = '0;
    first_tag  = '0;
    second_tag = '0;
    class_code = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // pop on an empty queue
    offer_word(OP_POP, 32'h0, 2'd0, 16'sd0, 8'sd0, 2'd0);
    // extreme field values, with several kinds and classes
    offer_word(OP_INSERT, 32'h0000_0100, 2'd0, 16'sd0, 8'sd0, 2'd0);
    offer_word(OP_INSERT, 32'hFFFF_FFFF, 2'd3, 16'h7FFF, 8'h7F, 2'd3);
    offer_word(OP_INSERT, 32'h0000_0000, 2'd1, 16'hFFFF, 8'hFF, 2'd1);
    // equal keys must leave in arrival order; most negative tags pass through
    offer_word(OP_INSERT, 32'h0000_0100, 2'd2, 16'h8000, 8'h80, 2'd2);
    offer_word(OP_INSERT, 32'h0000_0100, 2'd3, 16'sd1, 8'sd1, 2'd0);
    // fill to the brim, then one more insert is dropped as full
    repeat (DEPTH - 5) random_word(100);
    offer_word(OP_INSERT, 32'h0, 2'd1, 16'sd5, 8'sd5, 2'd1);
    // pops with junk in the ignored fields
    repeat (5) offer_word(OP_POP, $urandom, KindW'($urandom), Tag1W'($urandom),
                          Tag2W'($urandom), ClassW'($urandom));

    // random phases, the insert bias swings the queue between empty and full
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase % 6)
        0:       pct = 85;
        1:       pct = 15;
        2:       pct = 55;
        3:       pct = 95;
        4:       pct = 10;
        default: pct = 65;
      endcase
      quiet = (phase % 4 == 3);
      repeat (PHASE_WORDS) random_word(pct);
    end
    in_valid = 1'b0;
    quiet    = 1'b0;

    // drain, then give a late stray result a chance to show up
    while (pending != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sorted_event_queue_unit.f =====
hw/rtl/seq_pkg.sv
hw/rtl/seq_cell.sv
hw/rtl/sorted_event_queue_unit.sv
bench/event_order_checker.sv
bench/sorted_event_queue_unit_tb.sv
